@@ src/rscl_pkg.sv @@
package rscl_pkg;

  localparam logic [31:0] KEY0_RESET = 32'h06FADE60;
  localparam logic [31:0] KEY1_RESET = 32'hCAB4BEEF;
  localparam logic [31:0] KEY2_RESET = 32'h04866840;
  localparam logic [31:0] KEY3_RESET = 32'h80866808;
  localparam logic [63:0] TWEAK_SPREAD = 64'h0101010101010101;
  localparam logic [7:0] TWEAK_MASK = 8'hFF;
  localparam int CIPHER_ROUNDS = 27;
  localparam int SETS = 1024;

  localparam logic [2:0] REG_NUM_PARTITIONS = 3'd0;
  localparam logic [2:0] REG_INVALID_FIRST = 3'd1;
  localparam logic [2:0] REG_KEY0 = 3'd2;
  localparam logic [2:0] REG_KEY1 = 3'd3;
  localparam logic [2:0] REG_KEY2 = 3'd4;
  localparam logic [2:0] REG_KEY3 = 3'd5;

  localparam logic CMD_READ = 1'b0;
  localparam logic CMD_EVICT = 1'b1;

  typedef struct packed {
    logic cmd;
    logic [63:0] line_addr;
    logic [3:0] victim_way;
  } req_t;

  typedef struct packed {
    logic hit;
    logic evicted_valid;
    logic [63:0] evicted_line;
  } resp_t;

  typedef enum logic [1:0] {
    KX_IDLE,
    KX_RUN
  } kx_state_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CLEAR,
    BK_HASH,
    BK_SCAN,
    BK_WAIT,
    BK_DECIDE,
    BK_WRITE,
    BK_OUT
  } bk_state_t;

  function automatic logic [31:0] rotr8(input logic [31:0] v);
    return {v[7:0], v[31:8]};
  endfunction

  function automatic logic [31:0] rotl3(input logic [31:0] v);
    return {v[28:0], v[31:29]};
  endfunction

  function automatic logic [63:0] tweak_of(input logic [4:0] p);
    return 64'({3'd0, p} & TWEAK_MASK) * TWEAK_SPREAD;
  endfunction

endpackage

@@ src/rscl_keys.sv @@
module rscl_keys
  import rscl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] key0,
  input  logic [31:0] key1,
  input  logic [31:0] key2,
  input  logic [31:0] key3,
  input  logic [4:0]  rd_idx,
  output logic [31:0] rd_key,
  output logic        busy
);

  logic [31:0] rk [CIPHER_ROUNDS];
  logic [31:0] kcur;
  logic [31:0] lw [3];
  logic [4:0] i;
  logic [1:0] m;
  kx_state_t state, state_next;
  logic [31:0] x;

  always_comb begin
    x = (rotr8(lw[m]) + kcur) ^ {27'd0, i};
  end

  always_comb begin
    state_next = state;
    case (state)
      KX_IDLE: if (start) state_next = KX_RUN;
      KX_RUN: if (!start && i == 5'(CIPHER_ROUNDS - 2)) state_next = KX_IDLE;
      default: state_next = KX_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= KX_RUN;
      kcur <= KEY0_RESET;
      rk[0] <= KEY0_RESET;
      lw[0] <= KEY1_RESET;
      lw[1] <= KEY2_RESET;
      lw[2] <= KEY3_RESET;
      i <= '0;
      m <= '0;
    end else begin
      state <= state_next;
      if (start) begin
        kcur <= key0;
        rk[0] <= key0;
        lw[0] <= key1;
        lw[1] <= key2;
        lw[2] <= key3;
        i <= '0;
        m <= '0;
      end else if (state == KX_RUN) begin
        lw[m] <= x;
        kcur <= rotl3(kcur) ^ x;
        rk[i + 5'd1] <= rotl3(kcur) ^ x;
        i <= i + 5'd1;
        m <= (m == 2'd2) ? 2'd0 : m + 2'd1;
      end
    end
  end

  assign rd_key = rk[rd_idx];
  assign busy = (state != KX_IDLE) || start;

endmodule

@@ src/rscl_front.sv @@
module rscl_front
  import rscl_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_data,
  output logic q_valid,
  input  logic q_ready,
  output req_t q_data
);

  req_t buf0, buf1;
  logic [1:0] cnt;
  logic push, pop;

  assign in_ready = (cnt != 2'd2);
  assign push = in_valid && in_ready;
  assign pop = q_valid && q_ready;
  assign q_valid = (cnt != 2'd0);
  assign q_data = buf0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (push && cnt == 2'd1) buf0 <= in_data;
      else buf0 <= buf1;
    end else if (push) begin
      if (cnt == 2'd0) buf0 <= in_data;
      else buf1 <= in_data;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    cnt == 2'd2 |-> !push) else $error("queue overflow");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt != 2'd3) else $error("queue count out of range");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> cnt != 2'd0) else $error("pop from empty queue");
`endif

endmodule

@@ src/randomized_skewed_cache_lookup.sv @@
// Per transaction: the Speck rounds for each partition hash the line address, then the
// ways are scanned (a hit ends the scan early), then decide, write and result.
// One transaction at a time in the back end, a 2-entry queue in front.
// Reset (synchronous, active high) expands the reset key and clears all WAYS*SETS
// entries of the valid memory, one entry per cycle, before the first transaction.
module randomized_skewed_cache_lookup
  import rscl_pkg::*;
#(
  parameter int WAYS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  req_t        in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output resp_t       out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int SW = $clog2(SETS);
  localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int AW = SW + WW;

  logic [4:0]  num_partitions;
  logic        invalid_first;
  logic [31:0] key0, key1, key2, key3;
  logic        kx_start, kx_busy;
  logic [4:0]  rd_idx;
  logic [31:0] rd_key;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_partitions <= 5'd1;
      invalid_first <= 1'b0;
      key0 <= KEY0_RESET;
      key1 <= KEY1_RESET;
      key2 <= KEY2_RESET;
      key3 <= KEY3_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NUM_PARTITIONS: num_partitions <= cfg_data[4:0];
        REG_INVALID_FIRST: invalid_first <= cfg_data[0];
        REG_KEY0: key0 <= cfg_data;
        REG_KEY1: key1 <= cfg_data;
        REG_KEY2: key2 <= cfg_data;
        REG_KEY3: key3 <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) kx_start <= 1'b0;
    else kx_start <= cfg_we && (cfg_index inside {REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3});
  end

  rscl_keys u_keys (
    .clk, .rst, .start(kx_start), .key0, .key1, .key2, .key3,
    .rd_idx, .rd_key, .busy(kx_busy)
  );

  logic q_valid, q_ready;
  req_t q_data;

  rscl_front u_front (
    .clk, .rst, .in_valid, .in_ready, .in_data, .q_valid, .q_ready, .q_data
  );

  // memories: tag+valid per (way, set)
  logic [63:0] tag_mem [WAYS*SETS];
  logic        val_mem [WAYS*SETS];
  logic [AW-1:0] m_addr;
  logic m_we;
  logic [63:0] m_wtag;
  logic m_wval, m_wtag_en;
  logic [63:0] m_rtag;
  logic m_rval;

  always_ff @(posedge clk) begin
    if (m_we) begin
      val_mem[m_addr] <= m_wval;
      if (m_wtag_en) tag_mem[m_addr] <= m_wtag;
    end
    m_rtag <= tag_mem[m_addr];
    m_rval <= val_mem[m_addr];
  end

  bk_state_t state, state_next;
  req_t cur;
  logic [4:0] parts;
  logic [WW:0] psize;
  logic [4:0] part;
  logic [WW:0] way;        // absolute way
  logic [SW-1:0] idx_tab [WAYS];
  logic [SW-1:0] clr;
  logic [4:0] rnd;
  logic [31:0] sx, sy;
  logic [63:0] tweak, tweak_nx;
  logic found;
  logic [WW-1:0] found_way, free_way, tgt_way;
  logic free_any;
  resp_t res;
  logic [WW-1:0] vic;

  // partition count handling, one entry per register value
  logic [4:0]    pe_tab [32];
  logic [WW:0]   ps_tab [32];
  logic [WW-1:0] vic_tab [16];
  logic [4:0]    parts_eff;

  for (genvar p = 0; p < 32; p++) begin : g_part_tab
    localparam int PD = (p == 0) ? 1 : p;
    localparam bit PART_OK = (p != 0) && (p <= WAYS) && ((WAYS % PD) == 0);
    localparam int PSIZE = PART_OK ? (WAYS / PD) : WAYS;
    assign pe_tab[p] = PART_OK ? 5'(p) : 5'd1;
    assign ps_tab[p] = (WW+1)'(PSIZE);
  end

  for (genvar v = 0; v < 16; v++) begin : g_vic_tab
    localparam int VW = v % WAYS;
    assign vic_tab[v] = WW'(VW);
  end

  assign parts_eff = pe_tab[num_partitions];

  assign tweak = tweak_of(part);
  assign tweak_nx = tweak_of(part + 5'd1);
  assign rd_idx = rnd;
  assign vic = vic_tab[cur.victim_way];

  logic [31:0] nx;
  assign nx = (rotr8(sx) + sy) ^ rd_key;

  logic last_way, last_part;
  assign last_way = (way == (WW+1)'(WAYS - 1));
  assign last_part = (part == parts - 5'd1);

  always_comb begin
    if (found) tgt_way = found_way;
    else if (invalid_first && free_any) tgt_way = free_way;
    else tgt_way = vic;
  end

  always_comb begin
    state_next = state;
    case (state)
      BK_CLEAR: if (clr == SW'(SETS - 1) && last_way && !kx_busy) state_next = BK_IDLE;
      BK_IDLE: if (q_valid && !kx_busy) state_next = BK_HASH;
      BK_HASH: if (rnd == 5'(CIPHER_ROUNDS - 1) && last_part) state_next = BK_SCAN;
      BK_SCAN: state_next = BK_WAIT;
      BK_WAIT: state_next = (m_rval && m_rtag == cur.line_addr) ? BK_DECIDE :
                            (last_way ? BK_DECIDE : BK_SCAN);
      BK_DECIDE: state_next = BK_WRITE;
      BK_WRITE: state_next = BK_OUT;
      BK_OUT: if (out_ready) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    m_addr = {WW'(way), idx_tab[WW'(way)]};
    m_we = 1'b0;
    m_wval = 1'b0;
    m_wtag = cur.line_addr;
    m_wtag_en = 1'b0;
    case (state)
      BK_CLEAR: begin
        m_we = 1'b1;
        m_addr = {WW'(way), clr};
      end
      BK_WRITE: begin
        m_addr = {tgt_way, idx_tab[tgt_way]};
        if (found) begin
          m_we = (cur.cmd == CMD_EVICT);
        end else if (cur.cmd == CMD_READ) begin
          m_we = 1'b1;
          m_wval = 1'b1;
          m_wtag_en = 1'b1;
        end
      end
      BK_DECIDE: m_addr = {tgt_way, idx_tab[tgt_way]};
      default: ;
    endcase
  end

  assign q_ready = (state == BK_IDLE) && !kx_busy;
  assign out_valid = (state == BK_OUT);
  assign out_data = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_CLEAR;
      clr <= '0;
      way <= '0;
    end else begin
      state <= state_next;
      case (state)
        BK_CLEAR: begin
          if (way == (WW+1)'(WAYS - 1)) begin
            way <= '0;
            clr <= clr + SW'(1);
          end else begin
            way <= way + 1'b1;
          end
        end
        BK_IDLE: begin
          if (q_valid && !kx_busy) begin
            cur <= q_data;
            parts <= parts_eff;
            psize <= ps_tab[num_partitions];
            part <= '0;
            rnd <= '0;
            sx <= q_data.line_addr[31:0];
            sy <= q_data.line_addr[63:32];
            found <= 1'b0;
            free_any <= 1'b0;
            way <= '0;
          end
        end
        BK_HASH: begin
          if (rnd == 5'(CIPHER_ROUNDS - 1)) begin
            for (int w = 0; w < WAYS; w++) begin
              if (w >= int'(part) * int'(psize) && w < (int'(part) + 1) * int'(psize))
                idx_tab[w] <= SW'({rotl3(sy) ^ nx, nx} ^ tweak);
            end
            rnd <= '0;
            part <= part + 5'd1;
            sx <= cur.line_addr[31:0] ^ tweak_nx[31:0];
            sy <= cur.line_addr[63:32] ^ tweak_nx[63:32];
          end else begin
            rnd <= rnd + 5'd1;
            sx <= nx;
            sy <= rotl3(sy) ^ nx;
          end
        end
        BK_WAIT: begin
          if (m_rval && m_rtag == cur.line_addr) begin
            found <= 1'b1;
            found_way <= WW'(way);
          end else begin
            if (!m_rval) begin
              free_any <= 1'b1;
              free_way <= WW'(way);
            end
            if (!last_way) way <= way + 1'b1;
          end
        end
        BK_DECIDE: begin
          res <= '0;
        end
        BK_WRITE: begin
          if (found) begin
            res.hit <= 1'b1;
            if (cur.cmd == CMD_EVICT) begin
              res.evicted_valid <= 1'b1;
              res.evicted_line <= cur.line_addr;
            end
          end else if (cur.cmd == CMD_READ && !(invalid_first && free_any) && m_rval) begin
            res.evicted_valid <= 1'b1;
            res.evicted_line <= m_rtag;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTH
  a_out_one: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !q_ready) else $error("accept while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("result changed");
  a_evict_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.evicted_valid && cur.cmd == CMD_EVICT |-> out_data.hit)
    else $error("evict without hit");
`endif

endmodule
